>>> rtl/fse_pkg.sv
// ----------------------------------------------------------------------------
// fse_pkg
// Shared types, constants and helper functions of the Fourier series engine.
// ----------------------------------------------------------------------------
package fse_pkg;

  // Capacity and phase format.
  localparam int MaxDegree = 64;
  localparam int PhaseBits = 16;
  localparam int AddrW     = $clog2(MaxDegree + 1);
  localparam int Depth     = MaxDegree + 1;

  localparam int DataW  = 32;
  localparam int IdxW   = 7;
  localparam int ProdW  = 66;
  localparam int OperW  = 33;
  localparam int AccW   = 41;
  localparam int TermW  = 36;

  localparam logic [PhaseBits-1:0] QuarterTurn = PhaseBits'(1 << (PhaseBits - 2));

  // Odd polynomial of sin(pi/2*z) in Q30, highest order first.
  localparam logic [31:0] PolyC [5] = '{
    32'd172272, 32'd5026996, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  // Configuration register indexes.
  localparam logic [2:0] CfgDegree     = 3'd0;
  localparam logic [2:0] CfgInvPeriod  = 3'd1;
  localparam logic [2:0] CfgSubint     = 3'd2;
  localparam logic [2:0] CfgInvSubint  = 3'd3;
  localparam logic [2:0] CfgStartPhase = 3'd4;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_EVAL   = 2'd2,
    OP_SAMPLE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    logic [6:0]  degree;
    logic [31:0] inv_period;
    logic [15:0] subint;
    logic [31:0] inv_subint;
    logic [15:0] start_phase;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [6:0]  index;
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] position;
    logic [31:0] sample_value;
    logic [15:0] sample_index;
  } item_t;

  typedef struct packed {
    logic [31:0] value_a;
    logic [31:0] value_b;
    status_e     status;
  } res_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  // Clamp a wide signed value to the 32-bit range.
  function automatic sat_t sat32(input logic signed [AccW-1:0] v);
    sat_t r;
    if (v > $signed(AccW'(32'sh7fffffff))) begin
      r.sat = 1'b1;
      r.val = 32'h7fffffff;
    end else if (v < -$signed(AccW'(64'h80000000))) begin
      r.sat = 1'b1;
      r.val = 32'h80000000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Product divided by 2^30, rounded half up.
  function automatic logic [TermW-1:0] round30(input logic [ProdW-1:0] p);
    logic [ProdW-1:0] s;
    s = p + ProdW'(1 << 29);
    return s[ProdW-1:30];
  endfunction

endpackage

>>> rtl/fse_mul.sv
// ----------------------------------------------------------------------------
// fse_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fse_mul
  import fse_pkg::*;
(
  input  logic             clk_i,
  input  logic [OperW-1:0] a_i,
  input  logic [OperW-1:0] b_i,
  output logic [ProdW-1:0] p_o
);

  logic [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'($signed(a_i) * $signed(b_i));
  end

  assign p_o = p_q;

endmodule

>>> rtl/fse_coef_mem.sv
// ----------------------------------------------------------------------------
// fse_coef_mem
// Coefficient store: one pair {a, b} per harmonic, with registered read data.
// Entries that were never written since reset or a clear read as zero.
// ----------------------------------------------------------------------------
module fse_coef_mem
  import fse_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [63:0]      wdata_i,
  output logic [31:0]      rd_a_o,
  output logic [31:0]      rd_b_o
);

  logic [63:0]      mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [63:0]      rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rd_a_o = rvalid_q ? rdata_q[63:32] : 32'd0;
  assign rd_b_o = rvalid_q ? rdata_q[31:0]  : 32'd0;

endmodule

>>> rtl/fse_core.sv
// ----------------------------------------------------------------------------
// fse_core
// Operation sequencer: decodes an item, walks the harmonics through the
// shared multiplier and the coefficient store, and holds the result.
// ----------------------------------------------------------------------------
module fse_core
  import fse_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output logic  idle_o,
  output logic  res_valid_o,
  output res_t  res_o,
  input  logic  res_take_i
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDisp   = 4'd1;
  localparam logic [3:0] SRdWait = 4'd2;
  localparam logic [3:0] SEvPh   = 4'd3;
  localparam logic [3:0] SEvA0   = 4'd4;
  localparam logic [3:0] SSmPh   = 4'd5;
  localparam logic [3:0] SSmG    = 4'd6;
  localparam logic [3:0] SLoop   = 4'd7;
  localparam logic [3:0] SFinish = 4'd8;
  localparam logic [3:0] SDone   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [AddrW-1:0] i_q, i_d;
  logic [PhaseBits-1:0] h_q, h_d, t_q, t_d;
  logic [30:0] z_q, z_d, w_q, w_d;
  logic [1:0]  quad_q, quad_d;
  logic [31:0] sin_q, sin_d, na_q, na_d;
  logic [OperW-1:0] wg_q, wg_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic sat_q, sat_d;
  item_t item_q;
  res_t  res_q, res_d;

  logic [OperW-1:0] mul_a, mul_b;
  logic [ProdW-1:0] p;
  logic mem_re, mem_we, mem_clr;
  logic [AddrW-1:0] mem_raddr, mem_waddr;
  logic [63:0] mem_wdata;
  logic [31:0] rd_a, rd_b;

  logic [AddrW-1:0] n_eff;
  logic [PhaseBits-1:0] u;
  logic [30:0] z_new;
  logic [1:0]  quad_new;
  logic [31:0] p_hi, trig_res;
  logic [2:0]  ps;
  logic [31:0] ph32;
  logic [ProdW-1:0] gsum;
  logic [31:0] g;
  logic [TermW-1:0] term;
  sat_t sres;
  logic is_eval;

  fse_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  fse_coef_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (mem_clr),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rd_a_o  (rd_a),
    .rd_b_o  (rd_b)
  );

  assign n_eff = (32'(cfg_i.degree) > MaxDegree) ? AddrW'(MaxDegree) : AddrW'(cfg_i.degree);
  assign is_eval = (item_q.op == OP_EVAL);

  // Quadrant fold of the phase used by the current trig evaluation.
  always_comb begin
    u = (step_q == 4'd0) ? h_q : h_q + QuarterTurn;
    quad_new = u[PhaseBits-1:PhaseBits-2];
    z_new = {1'b0, u[PhaseBits-3:0], (32 - PhaseBits)'(0)};
    if (u[PhaseBits-2]) begin
      z_new = 31'(1 << 30) - z_new;
    end
  end

  assign p_hi     = p[61:30];
  assign trig_res = quad_q[1] ? (32'd0 - p_hi) : p_hi;
  assign ps       = (step_q >= 4'd6) ? 3'(step_q - 4'd6) : step_q[2:0];
  assign ph32     = {item_q.sample_index == 16'd0 ? cfg_i.start_phase : cfg_i.start_phase,
                     16'd0} + p[31:0];
  assign gsum     = p + ProdW'(64'h80000000);
  assign g        = gsum[63:32];
  assign term     = round30(p);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    i_d     = i_q;
    h_d     = h_q;
    t_d     = t_q;
    z_d     = z_q;
    w_d     = w_q;
    quad_d  = quad_q;
    sin_d   = sin_q;
    na_d    = na_q;
    wg_d    = wg_q;
    acc_d   = acc_q;
    sat_d   = sat_q;
    res_d   = res_q;
    mul_a   = '0;
    mul_b   = '0;
    mem_re  = 1'b0;
    mem_raddr = i_q;
    mem_we  = 1'b0;
    mem_waddr = i_q;
    mem_wdata = '0;
    mem_clr = 1'b0;
    sres    = '0;

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = SDisp;
        end
      end

      SDisp: begin
        res_d = '{value_a: 32'd0, value_b: 32'd0, status: ST_OK};
        sat_d = 1'b0;
        unique case (item_q.op)
          OP_WRITE: begin
            if (32'(item_q.index) > 32'(n_eff)) begin
              res_d.status = ST_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AddrW'(item_q.index);
              mem_wdata = {item_q.coef_a,
                           (item_q.index == 7'd0) ? 32'd0 : item_q.coef_b};
            end
            state_d = SDone;
          end
          OP_READ: begin
            if (32'(item_q.index) > 32'(n_eff)) begin
              res_d.status = ST_RANGE;
              state_d = SDone;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AddrW'(item_q.index);
              state_d   = SRdWait;
            end
          end
          OP_EVAL: begin
            mul_a   = {item_q.position[31], item_q.position};
            mul_b   = {1'b0, cfg_i.inv_period};
            state_d = SEvPh;
          end
          OP_SAMPLE: begin
            if (item_q.sample_index > cfg_i.subint) begin
              res_d.status = ST_RANGE;
              state_d = SDone;
            end else begin
              mem_clr = (item_q.sample_index == 16'd0);
              mul_a   = {17'd0, item_q.sample_index};
              mul_b   = {1'b0, cfg_i.inv_subint};
              state_d = SSmPh;
            end
          end
          default: state_d = SDone;
        endcase
      end

      SRdWait: begin
        res_d.value_a = rd_a;
        res_d.value_b = (item_q.index == 7'd0) ? 32'd0 : rd_b;
        state_d = SDone;
      end

      SEvPh: begin
        t_d       = p[39:40-PhaseBits];
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = SEvA0;
      end

      SEvA0: begin
        acc_d  = $signed({{(AccW-32){rd_a[31]}}, rd_a}) >>> 1;
        i_d    = AddrW'(1);
        h_d    = t_q;
        step_d = 4'd0;
        state_d = (n_eff == '0) ? SFinish : SLoop;
      end

      SSmPh: begin
        t_d     = ph32[31:32-PhaseBits];
        mul_a   = {item_q.sample_value[31], item_q.sample_value};
        mul_b   = {1'b0, cfg_i.inv_subint};
        state_d = SSmG;
      end

      SSmG: begin
        if (item_q.sample_index == 16'd0 || item_q.sample_index == cfg_i.subint) begin
          wg_d = {g[31], g};
        end else begin
          wg_d = {g, 1'b0};
        end
        i_d    = '0;
        h_d    = '0;
        step_d = 4'd0;
        state_d = SLoop;
      end

      SLoop: begin
        step_d = step_q + 4'd1;
        case (step_q) inside
          4'd0, 4'd6: begin
            if (step_q == 4'd0) begin
              mem_re    = 1'b1;
              mem_raddr = i_q;
            end else begin
              sin_d = trig_res;
            end
            z_d    = z_new;
            quad_d = quad_new;
            mul_a  = {2'b0, z_new};
            mul_b  = {2'b0, z_new};
          end
          4'd1, 4'd7: begin
            w_d   = p[60:30];
            mul_a = {2'b0, p[60:30]};
            mul_b = {1'b0, PolyC[0]};
          end
          4'd2, 4'd3, 4'd4, 4'd8, 4'd9, 4'd10: begin
            mul_a = {2'b0, w_q};
            mul_b = {1'b0, PolyC[ps-3'd1]} - {1'b0, p_hi};
          end
          4'd5, 4'd11: begin
            mul_a = {2'b0, z_q};
            mul_b = {1'b0, PolyC[4]} - {1'b0, p_hi};
          end
          4'd12: begin
            mul_a = is_eval ? {rd_a[31], rd_a} : wg_q;
            mul_b = {trig_res[31], trig_res};
          end
          4'd13: begin
            if (is_eval) begin
              acc_d = acc_q + $signed({{(AccW-TermW){term[TermW-1]}}, term});
            end else begin
              sres  = sat32($signed({{(AccW-32){rd_a[31]}}, rd_a})
                            + $signed({{(AccW-TermW){term[TermW-1]}}, term}));
              na_d  = sres.val;
              sat_d = sat_q | sres.sat;
            end
            mul_a = is_eval ? {rd_b[31], rd_b} : wg_q;
            mul_b = {sin_q[31], sin_q};
          end
          default: begin
            if (is_eval) begin
              acc_d = acc_q + $signed({{(AccW-TermW){term[TermW-1]}}, term});
            end else begin
              sres  = sat32($signed({{(AccW-32){rd_b[31]}}, rd_b})
                            + $signed({{(AccW-TermW){term[TermW-1]}}, term}));
              sat_d = sat_q | sres.sat;
              mem_we    = 1'b1;
              mem_waddr = i_q;
              mem_wdata = {na_q, sres.val};
            end
            step_d = 4'd0;
            if (i_q == n_eff) begin
              state_d = SFinish;
            end else begin
              i_d = i_q + AddrW'(1);
              h_d = h_q + t_q;
            end
          end
        endcase
      end

      SFinish: begin
        if (is_eval) begin
          sres = sat32(acc_q);
          res_d.value_a = sres.val;
          res_d.status  = sres.sat ? ST_SAT : ST_OK;
        end else begin
          res_d.status = sat_q ? ST_SAT : ST_OK;
        end
        state_d = SDone;
      end

      SDone: begin
        if (res_take_i) begin
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      step_q  <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      item_q <= item_i;
    end
    h_q    <= h_d;
    t_q    <= t_d;
    z_q    <= z_d;
    w_q    <= w_d;
    quad_q <= quad_d;
    sin_q  <= sin_d;
    na_q   <= na_d;
    wg_q   <= wg_d;
    acc_q  <= acc_d;
    sat_q  <= sat_d;
    res_q  <= res_d;
  end

  assign idle_o      = (state_q == SIdle);
  assign res_valid_o = (state_q == SDone);
  assign res_o       = res_q;

endmodule

>>> rtl/fourier_series_engine.sv
// ----------------------------------------------------------------------------
// fourier_series_engine
// Truncated Fourier series: coefficient store, series evaluation and
// trapezoid-rule coefficient estimation in Q15.16 fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Moves
//  input     in_valid_i / in_ready_o    one item: op and its operands
//  output    out_valid_o / out_ready_i  one item: value_a, value_b, status
//  config    cfg_we_i                   one register write, no wait
//
// A read passes a wait state for the store; a write or a range error does not.
// Evaluate walks harmonics 1 to n and a sample harmonics 0 to n, with n the
// degree in use: each harmonic runs 14 products through the one shared
// multiplier (two polynomial sines and two coefficient products).
// After reset every coefficient reads as zero; no clearing pass is needed.
// A finished result sits in the output register; the next item is taken
// while it waits, and the sequencer stalls only if a second result is done.
//
module fourier_series_engine
  import fse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [6:0]  index_i,
  input  logic [31:0] coef_a_in_i,
  input  logic [31:0] coef_b_in_i,
  input  logic [31:0] position_i,
  input  logic [31:0] sample_value_i,
  input  logic [15:0] sample_index_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_a_o,
  output logic [31:0] value_b_o,
  output logic [1:0]  status_o,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  cfg_t  cfg_q;
  item_t item;
  res_t  core_res;
  res_t  out_q;
  logic  out_valid_q;
  logic  core_idle;
  logic  core_res_valid;
  logic  res_take;
  logic  start;

  // Configuration registers; the user must write them only while no item is in flight (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.degree      <= 7'd1;
      cfg_q.inv_period  <= 32'h0100_0000;
      cfg_q.subint      <= 16'd1;
      cfg_q.inv_subint  <= 32'hffff_ffff;
      cfg_q.start_phase <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgDegree:     cfg_q.degree      <= cfg_wdata_i[6:0];
        CfgInvPeriod:  cfg_q.inv_period  <= cfg_wdata_i;
        CfgSubint:     cfg_q.subint      <= cfg_wdata_i[15:0];
        CfgInvSubint:  cfg_q.inv_subint  <= cfg_wdata_i;
        CfgStartPhase: cfg_q.start_phase <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign item = '{
    op:           op_e'(op_i),
    index:        index_i,
    coef_a:       coef_a_in_i,
    coef_b:       coef_b_in_i,
    position:     position_i,
    sample_value: sample_value_i,
    sample_index: sample_index_i
  };

  // The sequencer takes one item at a time.
  assign in_ready_o = core_idle;
  assign start      = in_valid_i && core_idle;

  fse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .idle_o      (core_idle),
    .res_valid_o (core_res_valid),
    .res_o       (core_res),
    .res_take_i  (res_take)
  );

  // Output register: it takes a finished result and frees the sequencer while empty or being read.
  assign res_take = core_res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_a_o   = out_q.value_a;
  assign value_b_o   = out_q.value_b;
  assign status_o    = out_q.status;

endmodule
